// ===== rtl/core/vcbts_pkg.sv =====
// Shared types and constants of the view cone target selector.
// Used by vcbts_cosine and view_cone_best_target_select_core.
package vcbts_pkg;

	localparam int COORD_BITS_DEF = 24;
	localparam int ID_BITS_DEF    = 16;

	localparam int COS_W     = 16;
	localparam int AIM_W     = 16;
	localparam int DIST_W    = 50;
	localparam int CFG_DW    = 50;
	localparam int CFG_IW    = 3;
	localparam int DOT_HI_W  = 20;
	localparam int DIV_STEPS = 16;

	localparam logic [63:0] HUGE_MAG = 64'h0000_0000_8000_0000;

	localparam logic signed [COS_W-1:0] COS_MAX  = 16'sh7fff;
	localparam logic signed [COS_W-1:0] COS_MIN  = 16'sh8000;
	localparam logic signed [COS_W-1:0] COS_ZERO = 16'sh0000;

	typedef enum logic [CFG_IW-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_AIM_X    = 3'd3,
		REG_AIM_Y    = 3'd4,
		REG_AIM_Z    = 3'd5,
		REG_MAX_DIST = 3'd6,
		REG_MIN_COS  = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_RANGE,
		ST_COS,
		ST_SCORE,
		ST_EMIT
	} core_state_t;

	typedef enum logic [2:0] {
		CU_IDLE,
		CU_SQRT,
		CU_CHK,
		CU_DIV,
		CU_DONE
	} cu_state_t;

	typedef struct packed {
		logic start;
		logic neg;
	} cos_req_t;

endpackage

// ===== rtl/core/vcbts_cosine.sv =====
// Serial cosine unit: floor square root of the squared distance, then a
// restoring divide of the dot magnitude by it, saturated to Q1.15.
// Depends on vcbts_pkg.
module vcbts_cosine #(
	parameter int COORD_BITS = vcbts_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  vcbts_pkg::cos_req_t                    req,
	input  logic [2*(COORD_BITS+1)-1:0]            dist_sq,
	input  logic [COORD_BITS+1+vcbts_pkg::DOT_HI_W-1:0] dot_mag,
	output logic                                   done,
	output logic signed [vcbts_pkg::COS_W-1:0]     cos_val
);

	localparam int MW    = COORD_BITS + 1;
	localparam int DW    = 2 * MW;
	localparam int DTW   = MW + vcbts_pkg::DOT_HI_W;
	localparam int QW    = vcbts_pkg::DIV_STEPS;
	localparam int CNT_W = $clog2((MW > QW) ? MW : QW);

	vcbts_pkg::cu_state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    rad_q;
	logic [MW:0]      rem_q;
	logic [MW-1:0]    root_q;
	logic [DTW-1:0]   dmag_q;
	logic [MW-1:0]    remd_q;
	logic [QW-1:0]    dlo_q;
	logic [QW-1:0]    quo_q;
	logic             ovf_q;
	logic             neg_q;

	logic [MW+2:0] sq_rem_n;
	logic [MW+2:0] sq_trial;
	logic          sq_ge;
	logic [MW:0]   dv_rn;
	logic          dv_ge;
	logic          ovf_now;
	logic          sat;
	logic          sqrt_en, chk_en, div_en;

	assign sq_rem_n = {rem_q, rad_q[DW-1 -: 2]};
	assign sq_trial = (MW+3)'({root_q, 2'b01});
	assign sq_ge    = sq_rem_n >= sq_trial;
	assign dv_rn    = {remd_q, dlo_q[QW-1]};
	assign dv_ge    = dv_rn >= {1'b0, root_q};
	assign ovf_now  = dmag_q[DTW-1:QW] >= (DTW-QW)'(root_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vcbts_pkg::CU_IDLE: if (req.start) state_d = vcbts_pkg::CU_SQRT;
			vcbts_pkg::CU_SQRT: if (cnt_q == '0) state_d = vcbts_pkg::CU_CHK;
			vcbts_pkg::CU_CHK:  state_d = vcbts_pkg::CU_DIV;
			vcbts_pkg::CU_DIV:  if (cnt_q == '0) state_d = vcbts_pkg::CU_DONE;
			vcbts_pkg::CU_DONE: state_d = vcbts_pkg::CU_IDLE;
			default:            state_d = vcbts_pkg::CU_IDLE;
		endcase
	end

	always_comb begin
		sqrt_en = 1'b0;
		chk_en  = 1'b0;
		div_en  = 1'b0;
		done    = 1'b0;
		unique case (state_q)
			vcbts_pkg::CU_IDLE: ;
			vcbts_pkg::CU_SQRT: sqrt_en = 1'b1;
			vcbts_pkg::CU_CHK:  chk_en  = 1'b1;
			vcbts_pkg::CU_DIV:  div_en  = 1'b1;
			vcbts_pkg::CU_DONE: done    = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vcbts_pkg::CU_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vcbts_pkg::CU_IDLE && req.start) begin
				cnt_q <= CNT_W'(MW - 1);
			end else if (chk_en) begin
				cnt_q <= CNT_W'(QW - 1);
			end else if (sqrt_en || div_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == vcbts_pkg::CU_IDLE && req.start) begin
			rad_q  <= dist_sq;
			rem_q  <= '0;
			root_q <= '0;
			dmag_q <= dot_mag;
			neg_q  <= req.neg;
		end
		if (sqrt_en) begin
			rad_q  <= {rad_q[DW-3:0], 2'b00};
			rem_q  <= sq_ge ? (MW+1)'(sq_rem_n - sq_trial) : (MW+1)'(sq_rem_n);
			root_q <= {root_q[MW-2:0], sq_ge};
		end
		if (chk_en) begin
			ovf_q  <= ovf_now;
			remd_q <= dmag_q[QW +: MW];
			dlo_q  <= dmag_q[QW-1:0];
			quo_q  <= '0;
		end
		if (div_en) begin
			remd_q <= dv_ge ? MW'(dv_rn - {1'b0, root_q}) : MW'(dv_rn);
			dlo_q  <= {dlo_q[QW-2:0], 1'b0};
			quo_q  <= {quo_q[QW-2:0], dv_ge};
		end
	end

	assign sat = ovf_q || quo_q[QW-1];

	always_comb begin
		if (neg_q) begin
			cos_val = sat ? vcbts_pkg::COS_MIN : $signed(~quo_q + 1'b1);
		end else begin
			cos_val = sat ? vcbts_pkg::COS_MAX : $signed(quo_q);
		end
	end

endmodule

// ===== rtl/core/view_cone_best_target_select_core.sv =====
// Top level of the view cone best target selector: config registers, serial
// distance and dot product, scoring and result register.
// Depends on vcbts_pkg and vcbts_cosine.
//
// Channel   Dir  Handshake            Payload
// s_axis    in   s_tvalid/s_tready    s_tdata pos_x,pos_y,pos_z,cand_id; s_tuser; s_tlast
// m_axis    out  m_tvalid/m_tready    m_tdata best_id,best_score; m_tuser found
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An eligible item in range passes through the bit-serial multiply, the serial square
// root and the 16-step divide unless its distance is zero; one rejected on range skips
// the root and divide, and an ineligible one is dropped when accepted. A last item also
// passes through ST_EMIT, which loads the result register once the output is free.
// One item is processed at a time; s_tready is high only when idle.
// The result register holds until taken; the next item is accepted meanwhile.
// Reset clears config registers, best state and the output valid.
module view_cone_best_target_select_core #(
	parameter int COORD_BITS = vcbts_pkg::COORD_BITS_DEF,
	parameter int ID_BITS    = vcbts_pkg::ID_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// pos_x, pos_y, pos_z, cand_id, zero pad
	input  logic [((3*COORD_BITS+ID_BITS+7)/8)*8-1:0] s_tdata,
	// eligible
	input  logic                                      s_tuser,
	input  logic                                      s_tlast,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// best_id, best_score, zero pad
	output logic [((ID_BITS+vcbts_pkg::COS_W+7)/8)*8-1:0] m_tdata,
	// found
	output logic                                      m_tuser,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [vcbts_pkg::CFG_IW-1:0]              cfg_index,
	input  logic [vcbts_pkg::CFG_DW-1:0]              cfg_data
);

	localparam int CB    = COORD_BITS;
	localparam int MW    = CB + 1;
	localparam int DW    = 2 * MW;
	localparam int DHW   = vcbts_pkg::DOT_HI_W;
	localparam int DTW   = MW + DHW;
	localparam int AW    = vcbts_pkg::AIM_W;
	localparam int CW    = vcbts_pkg::COS_W;
	localparam int MXW   = vcbts_pkg::DIST_W;
	localparam int CMPW  = (DW > MXW) ? DW : MXW;
	localparam int MCW   = $clog2(MW);
	localparam int OW    = ((ID_BITS + CW + 7) / 8) * 8;

	vcbts_pkg::core_state_t state_q, state_d;

	logic [CB-1:0]        org_q [3];
	logic [AW-1:0]        aim_q [3];
	logic [MXW-1:0]       max_dist_q;
	logic signed [CW-1:0] min_cos_q;

	logic [MW-1:0]   d_q     [3];
	logic [MW-1:0]   mcand_q [3];
	logic [MW-1:0]   mplr_q  [3];
	logic [AW:0]     sa_q    [3];
	logic            huge_q;
	logic [MW+2:0]   sq_hi_q;
	logic [MW-1:0]   sq_lo_q;
	logic [DHW-1:0]  dt_hi_q;
	logic [MW-1:0]   dt_lo_q;
	logic [MCW-1:0]  mcnt_q;
	logic [ID_BITS-1:0] id_q;
	logic            last_q;
	logic signed [CW-1:0] cos_q;

	logic signed [CW-1:0] best_cos_q;
	logic [ID_BITS-1:0]   best_id_q;
	logic                 have_q;

	logic                 m_tvalid_q;
	logic [ID_BITS-1:0]   m_id_q;
	logic                 m_found_q;
	logic signed [CW-1:0] m_score_q;

	logic [MW+2:0]  sq_sum;
	logic [DHW-1:0] dt_sum;
	logic [MW-1:0]  d_abs [3];
	logic           huge_any;
	logic [DW-1:0]  dist_sq;
	logic [DTW-1:0] dot_full;
	logic [DTW-1:0] dot_mag;
	logic           reject;
	logic           dist_zero;
	logic           out_free;
	logic           better;
	logic           cu_done;
	logic signed [CW-1:0] cu_cos;
	vcbts_pkg::cos_req_t  cu_req;

	logic in_take, do_prep, do_mul, do_range, do_cos, do_score, do_emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				org_q[k] <= '0;
				aim_q[k] <= '0;
			end
			max_dist_q <= '0;
			min_cos_q  <= '0;
		end else if (cfg_valid) begin
			unique case (vcbts_pkg::cfg_reg_t'(cfg_index))
				vcbts_pkg::REG_ORIGIN_X: org_q[0]   <= cfg_data[CB-1:0];
				vcbts_pkg::REG_ORIGIN_Y: org_q[1]   <= cfg_data[CB-1:0];
				vcbts_pkg::REG_ORIGIN_Z: org_q[2]   <= cfg_data[CB-1:0];
				vcbts_pkg::REG_AIM_X:    aim_q[0]   <= cfg_data[AW-1:0];
				vcbts_pkg::REG_AIM_Y:    aim_q[1]   <= cfg_data[AW-1:0];
				vcbts_pkg::REG_AIM_Z:    aim_q[2]   <= cfg_data[AW-1:0];
				vcbts_pkg::REG_MAX_DIST: max_dist_q <= cfg_data[MXW-1:0];
				vcbts_pkg::REG_MIN_COS:  min_cos_q  <= $signed(cfg_data[CW-1:0]);
			endcase
		end
	end

	always_comb begin
		sq_sum = sq_hi_q;
		dt_sum = dt_hi_q;
		for (int k = 0; k < 3; k++) begin
			if (mplr_q[k][0]) begin
				sq_sum = sq_sum + (MW+3)'(mcand_q[k]);
				dt_sum = dt_sum + {{(DHW-AW-1){sa_q[k][AW]}}, sa_q[k]};
			end
		end
	end

	always_comb begin
		huge_any = 1'b0;
		for (int k = 0; k < 3; k++) begin
			d_abs[k] = d_q[k][MW-1] ? (~d_q[k] + 1'b1) : d_q[k];
			if (64'(d_abs[k]) >= vcbts_pkg::HUGE_MAG) begin
				huge_any = 1'b1;
			end
		end
	end

	assign dist_sq   = {sq_hi_q[MW-1:0], sq_lo_q};
	assign dot_full  = {dt_hi_q, dt_lo_q};
	assign dot_mag   = dot_full[DTW-1] ? (~dot_full + 1'b1) : dot_full;
	assign reject    = huge_q || (CMPW'(dist_sq) > CMPW'(max_dist_q));
	assign dist_zero = (dist_sq == '0);
	assign out_free  = !m_tvalid_q || m_tready;
	assign better    = (cos_q >= min_cos_q) && (!have_q || cos_q > best_cos_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vcbts_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser) state_d = vcbts_pkg::ST_PREP;
					else if (s_tlast) state_d = vcbts_pkg::ST_EMIT;
				end
			end
			vcbts_pkg::ST_PREP: state_d = vcbts_pkg::ST_MUL;
			vcbts_pkg::ST_MUL: if (mcnt_q == '0) state_d = vcbts_pkg::ST_RANGE;
			vcbts_pkg::ST_RANGE: begin
				priority if (reject) begin
					state_d = last_q ? vcbts_pkg::ST_EMIT : vcbts_pkg::ST_IDLE;
				end else if (dist_zero) begin
					state_d = vcbts_pkg::ST_SCORE;
				end else begin
					state_d = vcbts_pkg::ST_COS;
				end
			end
			vcbts_pkg::ST_COS: if (cu_done) state_d = vcbts_pkg::ST_SCORE;
			vcbts_pkg::ST_SCORE: state_d = last_q ? vcbts_pkg::ST_EMIT : vcbts_pkg::ST_IDLE;
			vcbts_pkg::ST_EMIT: if (out_free) state_d = vcbts_pkg::ST_IDLE;
			default: state_d = vcbts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		do_prep  = 1'b0;
		do_mul   = 1'b0;
		do_range = 1'b0;
		do_cos   = 1'b0;
		do_score = 1'b0;
		do_emit  = 1'b0;
		unique case (state_q)
			vcbts_pkg::ST_IDLE:  s_tready = 1'b1;
			vcbts_pkg::ST_PREP:  do_prep  = 1'b1;
			vcbts_pkg::ST_MUL:   do_mul   = 1'b1;
			vcbts_pkg::ST_RANGE: do_range = 1'b1;
			vcbts_pkg::ST_COS:   do_cos   = 1'b1;
			vcbts_pkg::ST_SCORE: do_score = 1'b1;
			vcbts_pkg::ST_EMIT:  do_emit  = out_free;
			default: ;
		endcase
	end

	assign in_take    = s_tready && s_tvalid;
	assign cu_req.start = do_range && !reject && !dist_zero;
	assign cu_req.neg   = dot_full[DTW-1];

	vcbts_cosine #(
		.COORD_BITS(COORD_BITS)
	) u_cosine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cu_req),
		.dist_sq(dist_sq),
		.dot_mag(dot_mag),
		.done   (cu_done),
		.cos_val(cu_cos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vcbts_pkg::ST_IDLE;
			mcnt_q     <= '0;
			best_cos_q <= '0;
			best_id_q  <= '0;
			have_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_prep) begin
				mcnt_q <= MCW'(MW - 1);
			end else if (do_mul) begin
				mcnt_q <= mcnt_q - 1'b1;
			end
			if (do_score && better) begin
				best_cos_q <= cos_q;
				best_id_q  <= id_q;
				have_q     <= 1'b1;
			end
			if (do_emit) begin
				m_tvalid_q <= 1'b1;
				best_cos_q <= '0;
				best_id_q  <= '0;
				have_q     <= 1'b0;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			for (int k = 0; k < 3; k++) begin
				d_q[k] <= {s_tdata[k*CB+CB-1], s_tdata[k*CB +: CB]}
					- {org_q[k][CB-1], org_q[k]};
			end
			id_q   <= s_tdata[3*CB +: ID_BITS];
			last_q <= s_tlast;
		end
		if (do_prep) begin
			huge_q  <= huge_any;
			sq_hi_q <= '0;
			sq_lo_q <= '0;
			dt_hi_q <= '0;
			dt_lo_q <= '0;
			for (int k = 0; k < 3; k++) begin
				mcand_q[k] <= d_abs[k];
				mplr_q[k]  <= d_abs[k];
				sa_q[k]    <= d_q[k][MW-1] ? (~{aim_q[k][AW-1], aim_q[k]} + 1'b1)
					: {aim_q[k][AW-1], aim_q[k]};
			end
		end
		if (do_mul) begin
			sq_hi_q <= {1'b0, sq_sum[MW+2:1]};
			sq_lo_q <= {sq_sum[0], sq_lo_q[MW-1:1]};
			dt_hi_q <= {dt_sum[DHW-1], dt_sum[DHW-1:1]};
			dt_lo_q <= {dt_sum[0], dt_lo_q[MW-1:1]};
			for (int k = 0; k < 3; k++) begin
				mplr_q[k] <= {1'b0, mplr_q[k][MW-1:1]};
			end
		end
		if (do_range && dist_zero) begin
			cos_q <= vcbts_pkg::COS_ZERO;
		end
		if (do_cos && cu_done) begin
			cos_q <= cu_cos;
		end
		if (do_emit) begin
			m_id_q    <= have_q ? best_id_q : '0;
			m_found_q <= have_q;
			m_score_q <= have_q ? best_cos_q : vcbts_pkg::COS_ZERO;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = OW'({m_score_q, m_id_q});

endmodule

// ===== verif/view_cone_best_target_select_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for view_cone_best_target_select_core: directed and random candidate queries
// under random stream stalls, checked against a cycle-free predictor of the selection.
// Depends on vcbts_pkg and the RTL of the core.
module view_cone_best_target_select_core_tb;
	import vcbts_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int IB = ID_BITS_DEF;
	localparam int S_DW = ((3*CB+IB+7)/8)*8;
	localparam int M_DW = ((IB+COS_W+7)/8)*8;
	localparam int RANDOM_ITEMS = 500;
	localparam int SETTLE_CYCLES = 100;
	localparam logic [DIST_W-1:0] RANGE_ALL = '1;

	typedef struct packed {
		logic signed [CB-1:0] px;
		logic signed [CB-1:0] py;
		logic signed [CB-1:0] pz;
		logic [IB-1:0]        id;
		logic                 elig;
		logic                 lst;
	} cand_t;

	typedef struct packed {
		logic [IB-1:0]           id;
		logic                    found;
		logic signed [COS_W-1:0] score;
	} pick_t;

	logic clk;
	logic arst_n;
	logic [S_DW-1:0] s_tdata;
	logic s_tuser;
	logic s_tlast;
	logic s_tvalid;
	logic s_tready;
	logic [M_DW-1:0] m_tdata;
	logic m_tuser;
	logic m_tvalid;
	logic m_tready;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	// view settings as the block should hold them
	logic signed [CB-1:0]    org_x, org_y, org_z;
	logic signed [AIM_W-1:0] aim_x, aim_y, aim_z;
	logic [DIST_W-1:0]       range_limit;
	logic signed [COS_W-1:0] cos_floor;

	// running best of the open query
	int            lead_cos;
	logic [IB-1:0] lead_id;
	logic          lead_valid;

	cand_t candidate_q[$];
	pick_t expected_picks[$];
	int    mismatches;
	bit    no_gaps;
	bit    s_fire, m_fire;
	int unsigned send_gap, ready_stall;

	view_cone_best_target_select_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] floor_root(logic [63:0] v);
		logic [31:0] r;
		logic [31:0] t;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if ({32'd0, t} * {32'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	task automatic score_candidate(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz, logic [IB-1:0] id);
		longint dx, dy, dz, dot;
		logic [63:0] range_sq, q;
		int c;
		dx = longint'(px) - longint'(org_x);
		dy = longint'(py) - longint'(org_y);
		dz = longint'(pz) - longint'(org_z);
		range_sq = dx*dx + dy*dy + dz*dz;
		if (range_sq > {14'd0, range_limit})
			return;
		dot = dx*longint'(aim_x) + dy*longint'(aim_y) + dz*longint'(aim_z);
		if (range_sq == 0) begin
			c = 0;
		end else begin
			q = (dot < 0 ? -dot : dot) / floor_root(range_sq);
			if (dot < 0)
				c = (q > 64'd32768) ? -32768 : -int'(q);
			else
				c = (q > 64'd32767) ? 32767 : int'(q);
		end
		if (c < int'(cos_floor))
			return;
		if (!lead_valid || c > lead_cos) begin
			lead_cos = c;
			lead_id = id;
			lead_valid = 1'b1;
		end
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : observe
		pick_t want;
		if (!arst_n) begin
			s_fire <= 1'b0;
			m_fire <= 1'b0;
		end else begin
			s_fire <= s_tvalid && s_tready;
			m_fire <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				if (s_tuser)
					score_candidate(s_tdata[CB-1:0], s_tdata[2*CB-1:CB],
						s_tdata[3*CB-1:2*CB], s_tdata[3*CB+IB-1:3*CB]);
				if (s_tlast) begin
					want.id = lead_valid ? lead_id : '0;
					want.found = lead_valid;
					want.score = lead_valid ? COS_W'(lead_cos) : COS_ZERO;
					expected_picks.push_back(want);
					lead_cos = 0;
					lead_id = '0;
					lead_valid = 1'b0;
				end
			end
			if (m_tvalid && m_tready) begin
				if (expected_picks.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result transfer: expected none got %h/%b",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_picks.pop_front();
					check_field("best_id", want.id, m_tdata[IB-1:0]);
					check_field("found", 16'(want.found), 16'(m_tuser));
					check_field("best_score", want.score, m_tdata[IB+COS_W-1:IB]);
				end
			end
		end
	end

	always @(negedge clk) begin : feed
		cand_t cur;
		if (arst_n && (!s_tvalid || s_fire)) begin
			if (candidate_q.size() != 0 && send_gap == 0) begin
				cur = candidate_q.pop_front();
				s_tdata <= S_DW'({cur.id, cur.pz, cur.py, cur.px});
				s_tuser <= cur.elig;
				s_tlast <= cur.lst;
				s_tvalid <= 1'b1;
				send_gap <= no_gaps ? 0 : $urandom_range(0, 6);
			end else begin
				s_tvalid <= 1'b0;
				if (send_gap != 0)
					send_gap <= send_gap - 1;
			end
		end
	end

	always @(negedge clk) begin : drain
		int unsigned k;
		if (arst_n) begin
			if (m_fire) begin
				k = no_gaps ? 0 : $urandom_range(0, 6);
				m_tready <= (k == 0);
				ready_stall <= k;
			end else if (ready_stall != 0) begin
				m_tready <= (ready_stall == 1);
				ready_stall <= ready_stall - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ORIGIN_X: org_x = val[CB-1:0];
			REG_ORIGIN_Y: org_y = val[CB-1:0];
			REG_ORIGIN_Z: org_z = val[CB-1:0];
			REG_AIM_X:    aim_x = val[AIM_W-1:0];
			REG_AIM_Y:    aim_y = val[AIM_W-1:0];
			REG_AIM_Z:    aim_z = val[AIM_W-1:0];
			REG_MAX_DIST: range_limit = val[DIST_W-1:0];
			REG_MIN_COS:  cos_floor = val[COS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// unused upper bits of cfg_data carry junk
	task automatic set_view(logic signed [CB-1:0] ox, logic signed [CB-1:0] oy,
			logic signed [CB-1:0] oz, logic signed [AIM_W-1:0] ax, logic signed [AIM_W-1:0] ay,
			logic signed [AIM_W-1:0] az, logic [DIST_W-1:0] lim, logic signed [COS_W-1:0] mc);
		write_reg(REG_ORIGIN_X, {(CFG_DW-CB)'($urandom), ox});
		write_reg(REG_ORIGIN_Y, {(CFG_DW-CB)'($urandom), oy});
		write_reg(REG_ORIGIN_Z, {(CFG_DW-CB)'($urandom), oz});
		write_reg(REG_AIM_X, {(CFG_DW-AIM_W)'({$urandom, $urandom}), ax});
		write_reg(REG_AIM_Y, {(CFG_DW-AIM_W)'({$urandom, $urandom}), ay});
		write_reg(REG_AIM_Z, {(CFG_DW-AIM_W)'({$urandom, $urandom}), az});
		write_reg(REG_MAX_DIST, lim);
		write_reg(REG_MIN_COS, {(CFG_DW-COS_W)'({$urandom, $urandom}), mc});
	endtask

	task automatic push(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz, logic [IB-1:0] id, logic elig, logic lst);
		cand_t c;
		c.px = px;
		c.py = py;
		c.pz = pz;
		c.id = id;
		c.elig = elig;
		c.lst = lst;
		candidate_q.push_back(c);
	endtask

	// hold until the block is idle and every result has been checked
	task automatic settle();
		while (candidate_q.size() != 0 || s_tvalid || expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [CB-1:0] near(logic signed [CB-1:0] o, int unsigned span);
		return CB'(int'(o) + int'($urandom_range(0, 2*span)) - int'(span));
	endfunction

	task automatic push_random(logic lst);
		int unsigned kind, span;
		logic signed [CB-1:0] px, py, pz;
		kind = $urandom_range(0, 9);
		span = 1 << $urandom_range(0, CB-1);
		if (kind < 6) begin
			px = near(org_x, span);
			py = near(org_y, span);
			pz = near(org_z, span);
		end else if (kind < 9) begin
			px = CB'($urandom);
			py = CB'($urandom);
			pz = CB'($urandom);
		end else begin
			px = org_x;
			py = org_y;
			pz = org_z;
		end
		push(px, py, pz, IB'($urandom), $urandom_range(0, 7) != 0, lst);
	endtask

	task automatic random_view();
		logic signed [AIM_W-1:0] a[3];
		logic [DIST_W-1:0] lim;
		logic signed [COS_W-1:0] mc;
		int unsigned axis;
		if ($urandom_range(0, 1) == 0) begin
			foreach (a[i]) a[i] = AIM_W'($urandom);
		end else begin
			axis = $urandom_range(0, 2);
			foreach (a[i]) a[i] = '0;
			a[axis] = $urandom_range(0, 1) ? COS_MAX : COS_MIN;
		end
		case ($urandom_range(0, 4))
			0: lim = '0;
			1: lim = RANGE_ALL;
			default: lim = DIST_W'({$urandom, $urandom}) >> $urandom_range(0, DIST_W-1);
		endcase
		case ($urandom_range(0, 4))
			0: mc = COS_MIN;
			1: mc = COS_MAX;
			2: mc = COS_ZERO;
			default: mc = COS_W'($urandom);
		endcase
		if ($urandom_range(0, 3) == 0)
			set_view(CB'($urandom), CB'($urandom), CB'($urandom), a[0], a[1], a[2], lim, mc);
		else
			set_view(near(0, 1 << 12), near(0, 1 << 12), near(0, 1 << 12),
				a[0], a[1], a[2], lim, mc);
	endtask

	initial begin
		int items, qlen;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		s_tvalid = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = '0;
		org_x = '0;
		org_y = '0;
		org_z = '0;
		aim_x = '0;
		aim_y = '0;
		aim_z = '0;
		range_limit = '0;
		cos_floor = '0;
		lead_cos = 0;
		lead_id = '0;
		lead_valid = 1'b0;
		mismatches = 0;
		no_gaps = 1'b0;
		send_gap = 0;
		ready_stall = 0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: only a zero offset is in range
		push(0, 0, 0, 16'h0042, 1'b1, 1'b1);
		settle();

		set_view(0, 0, 0, COS_MAX, 0, 0, RANGE_ALL, COS_MIN);
		push(0, 0, 0, 16'd1, 1'b1, 1'b1);
		push(5, 5, 5, 16'd7, 1'b0, 1'b1);
		// equal cosines keep the earlier one; ineligible last item closes the query
		push(100, 0, 0, 16'd10, 1'b1, 1'b0);
		push(300, 0, 0, 16'd11, 1'b1, 1'b0);
		push(-24'sd8388608, 24'sd8388607, -24'sd8388608, 16'd12, 1'b1, 1'b0);
		push(24'sd8388607, -24'sd8388608, 24'sd8388607, 16'hffff, 1'b1, 1'b0);
		push(0, 50, 0, 16'd0, 1'b1, 1'b0);
		push(9, 9, 9, 16'd3, 1'b0, 1'b1);
		push(-50, 0, 0, 16'd4, 1'b1, 1'b0);
		push(0, 0, -20, 16'd5, 1'b1, 1'b1);
		settle();

		set_view(1000, -2000, 3000, 16'sd23170, 16'sd23170, 0, '0, COS_MIN);
		push(1000, -2000, 3000, 16'd9, 1'b1, 1'b0);
		push(1001, -1999, 3000, 16'd8, 1'b1, 1'b1);
		settle();

		// floor root pushes the cosine past one in both directions
		set_view(1000, -2000, 3000, 16'sd23170, 16'sd23170, 0, RANGE_ALL, COS_ZERO);
		push(1001, -1999, 3000, 16'd21, 1'b1, 1'b0);
		push(999, -2001, 3000, 16'd22, 1'b1, 1'b0);
		push(1000, -2000, 3000, 16'd23, 1'b1, 1'b1);
		push(999, -2001, 3000, 16'd24, 1'b1, 1'b1);
		push(1001, -1999, 3000, 16'd25, 1'b1, 1'b1);
		settle();

		items = 0;
		while (items < RANDOM_ITEMS) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			random_view();
			repeat ($urandom_range(6, 12)) begin
				qlen = $urandom_range(1, 6);
				for (int j = 0; j < qlen; j++)
					push_random(j == qlen - 1);
				items += qlen;
			end
			settle();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
